// ===== rtl/core/planar_twist_pose_integrator_assert.svh =====
// Assertion macros for the planar twist pose integrator.
// Used by the top level only; needs clock and reset in scope.
`ifndef PLANAR_TWIST_POSE_INTEGRATOR_ASSERT_SVH
`define PLANAR_TWIST_POSE_INTEGRATOR_ASSERT_SVH
// implication checked on every clock edge outside reset
`define PTPI_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);
// implication checked on every edge, reset included
`define PTPI_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) (prop)) else $error(msg);
`endif

// ===== rtl/core/ptpi_pkg.sv =====
// Package for the planar twist pose integrator: widths, constants, codes.
// No dependencies.
`timescale 1ns / 1ps
package ptpi_pkg;
   localparam int CordicSteps  = 24;
   localparam int PosFracBits  = 16;
   localparam int RateW        = 31;
   localparam int ThrW         = 29;
   localparam int VelW         = 32;
   localparam int AccW         = 36;  // CORDIC accumulator, Q1.30 plus headroom
   localparam int NumW         = 68;  // numerator of the displacement division
   localparam int DenW         = 33;
   localparam int QuoW         = NumW;

   localparam logic [ThrW-1:0]  ThrReset    = ThrW'(268);
   localparam logic signed [AccW-1:0] OneQ30     = AccW'(64'sd1073741824);
   localparam logic signed [AccW-1:0] HalfPiQ30  = AccW'(64'sd1686629713);
   localparam logic signed [AccW-1:0] PiQ30      = AccW'(64'sd3373259426);
   localparam logic signed [AccW-1:0] GainQ30    = AccW'(64'sd652032874);
   localparam logic signed [33:0] PiQ28          = 34'sd843314857;
   localparam logic signed [33:0] TwoPiQ28       = 34'sd1686629713;
   localparam logic signed [33:0] DispLimit      = 34'sd4294967295;

   // controller commands
   typedef struct packed {
      logic load;       // latch input transaction
      logic cor_start;  // initialise CORDIC with angle select
      logic cor_sel;    // 0: rate, 1: new heading
      logic cor_step;
      logic num_x;      // numerator products, one per step
      logic num_y;
      logic num_c;
      logic num_d;
      logic div_start;
      logic div_step;
      logic div_sel;    // 0: dx, 1: dy
      logic div_done;   // store quotient
      logic rot_a;      // rotation product steps
      logic rot_b;
      logic rot_c;
      logic rot_d;
      logic pos_upd;
      logic pose_trig;  // store new cos/sin
      logic out_load;
   } cmd_type;

   typedef struct packed {
      logic turning;
   } sts_type;

   function automatic logic signed [AccW-1:0] atan_q30(input int i);
      logic signed [AccW-1:0] r;
      case (i)
         0: r = 36'sd843314857;  1: r = 36'sd497837829;  2: r = 36'sd263043837;
         3: r = 36'sd133525159;  4: r = 36'sd67021687;   5: r = 36'sd33543516;
         6: r = 36'sd16775851;   7: r = 36'sd8388437;    8: r = 36'sd4194283;
         9: r = 36'sd2097149;
         default: r = (i < 31) ? (AccW'(36'sd1) <<< (30 - i)) : '0;
      endcase
      return r;
   endfunction
endpackage

// ===== rtl/core/ptpi_if.sv =====
// Valid/ready stream interfaces for the input, result and csr channels.
// Depends on ptpi_pkg.
`timescale 1ns / 1ps
interface ptpi_req_if;
   logic valid;
   logic ready;
   logic signed [ptpi_pkg::RateW-1:0] rate_w;
   logic signed [ptpi_pkg::VelW-1:0]  vel_x;
   logic signed [ptpi_pkg::VelW-1:0]  vel_y;
   modport source (output valid, rate_w, vel_x, vel_y, input ready);
   modport sink   (input valid, rate_w, vel_x, vel_y, output ready);
endinterface

interface ptpi_rsp_if;
   logic valid;
   logic ready;
   logic signed [31:0] out_x;
   logic signed [31:0] out_y;
   logic signed [ptpi_pkg::RateW-1:0] out_theta;
   logic saturated;
   modport source (output valid, out_x, out_y, out_theta, saturated, input ready);
   modport sink   (input valid, out_x, out_y, out_theta, saturated, output ready);
endinterface

interface ptpi_csr_if;
   logic valid;
   logic ready;
   logic [ptpi_pkg::ThrW-1:0] data;
   modport source (output valid, data, input ready);
   modport sink   (input valid, data, output ready);
endinterface

// ===== rtl/core/planar_twist_pose_integrator.sv =====
// Straight steps skip the CORDIC passes and the divider; turning steps run two CORDIC
// passes and two bit-serial divisions (dx, then dy).
// Occupancy: one transaction in the core; the next is taken in the idle state after the
// result register loads, so a new transaction is not accepted before the last one ends.
// An untaken result stalls the core only when the next one is ready.
// Reset (synchronous, active high): pose to origin, heading 0, threshold 268.
`timescale 1ns / 1ps
`include "planar_twist_pose_integrator_assert.svh"
module planar_twist_pose_integrator #(
   parameter int CORDIC_STEPS  = ptpi_pkg::CordicSteps
) (
   input logic clock,
   input logic reset,
   ptpi_req_if.sink   req,
   ptpi_rsp_if.source rsp,
   ptpi_csr_if.sink   csr
);
   ptpi_pkg::cmd_type cmd;
   ptpi_pkg::sts_type sts;
   logic [4:0] step;
   logic [ptpi_pkg::ThrW-1:0] thr_ff;

   assign csr.ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) thr_ff <= ptpi_pkg::ThrReset;
      else if (csr.valid) thr_ff <= csr.data;
   end

   ptpi_ctrl #(.CORDIC_STEPS(CORDIC_STEPS)) u_ctrl (
      .clock, .reset, .in_valid(req.valid), .in_ready(req.ready),
      .out_valid(rsp.valid), .out_ready(rsp.ready), .sts, .cmd, .step
   );

   ptpi_datapath u_dp (
      .clock, .reset, .cmd, .sts, .step, .thr(thr_ff),
      .in_w(req.rate_w), .in_vx(req.vel_x), .in_vy(req.vel_y),
      .o_x(rsp.out_x), .o_y(rsp.out_y), .o_th(rsp.out_theta), .o_sat(rsp.saturated)
   );

   `PTPI_ASSERT(a_no_accept_busy, (req.valid && req.ready) |=> !req.ready, "accept while busy")
   `PTPI_ASSERT(a_rsp_hold, (rsp.valid && !rsp.ready) |=> rsp.valid, "result dropped")
   `PTPI_ASSERT_ALWAYS(a_reset_idle, reset |=> !rsp.valid, "result after reset")
endmodule

// ===== rtl/core/ptpi_datapath.sv =====
// Datapath: CORDIC, restoring divider, multiplies, pose registers.
// Depends on ptpi_pkg; driven by ptpi_ctrl.
`timescale 1ns / 1ps
module ptpi_datapath (
   input  logic clock,
   input  logic reset,
   input  ptpi_pkg::cmd_type cmd,
   output ptpi_pkg::sts_type sts,
   input  logic [4:0] step,
   input  logic [ptpi_pkg::ThrW-1:0] thr,
   input  logic signed [ptpi_pkg::RateW-1:0] in_w,
   input  logic signed [31:0] in_vx,
   input  logic signed [31:0] in_vy,
   output logic signed [31:0] o_x,
   output logic signed [31:0] o_y,
   output logic signed [ptpi_pkg::RateW-1:0] o_th,
   output logic o_sat
);
   localparam int A = ptpi_pkg::AccW;
   localparam int N = ptpi_pkg::NumW;

   logic signed [30:0] w_ff;
   logic signed [31:0] vx_ff, vy_ff;
   logic turn_ff;
   logic signed [31:0] px_ff, py_ff, th_ff, pc_ff, ps_ff;
   logic signed [A-1:0] cx_ff, cy_ff, ca_ff, cx_in, cy_in, ca_in;
   logic cneg_ff;
   logic signed [N-1:0] num_ff;
   logic signed [N-1:0] numx_ff, numy_ff;
   logic [N-1:0] rem_ff, quo_ff, rem_in;
   logic [32:0] dmag_ff;
   logic qneg_ff;
   logic signed [33:0] dx_ff, dy_ff;
   logic signed [67:0] acc_ff;
   logic signed [67:0] prod;
   logic sat_ff;
   logic signed [33:0] th_new;
   logic signed [A-1:0] cc, cs;

   // heading wrap (at most one correction needed for the field range)
   always_comb begin
      th_new = 34'(th_ff) + 34'(w_ff);
      if (th_new > ptpi_pkg::PiQ28) th_new = th_new - ptpi_pkg::TwoPiQ28;
      else if (th_new < -ptpi_pkg::PiQ28) th_new = th_new + ptpi_pkg::TwoPiQ28;
   end

   assign sts.turning = turn_ff;

   // corrected CORDIC outputs, clamped to +-1
   always_comb begin
      cc = cneg_ff ? -cx_ff : cx_ff;
      cs = cneg_ff ? -cy_ff : cy_ff;
      if (cc > ptpi_pkg::OneQ30) cc = ptpi_pkg::OneQ30;
      if (cc < -ptpi_pkg::OneQ30) cc = -ptpi_pkg::OneQ30;
      if (cs > ptpi_pkg::OneQ30) cs = ptpi_pkg::OneQ30;
      if (cs < -ptpi_pkg::OneQ30) cs = -ptpi_pkg::OneQ30;
   end

   always_comb begin
      logic signed [A-1:0] a;
      a = '0;
      cx_in = cx_ff; cy_in = cy_ff; ca_in = ca_ff;
      if (cmd.cor_start) begin
         a = cmd.cor_sel ? A'(th_new) <<< 2 : A'(w_ff) <<< 2;
         cx_in = ptpi_pkg::GainQ30; cy_in = '0;
         if (a > ptpi_pkg::HalfPiQ30) a = a - ptpi_pkg::PiQ30;
         else if (a < -ptpi_pkg::HalfPiQ30) a = a + ptpi_pkg::PiQ30;
         ca_in = a;
      end else if (cmd.cor_step) begin
         if (ca_ff >= 0) begin
            cx_in = cx_ff - (cy_ff >>> step);
            cy_in = cy_ff + (cx_ff >>> step);
            ca_in = ca_ff - ptpi_pkg::atan_q30(int'(step));
         end else begin
            cx_in = cx_ff + (cy_ff >>> step);
            cy_in = cy_ff - (cx_ff >>> step);
            ca_in = ca_ff + ptpi_pkg::atan_q30(int'(step));
         end
      end
   end

   // one shared 34x34 multiplier
   always_comb begin
      logic signed [33:0] ma, mb;
      ma = '0; mb = '0;
      if (cmd.num_x)      begin ma = 34'(cs); mb = 34'(vx_ff); end
      else if (cmd.num_y) begin ma = 34'(cc - ptpi_pkg::OneQ30); mb = 34'(vy_ff); end
      else if (cmd.num_c) begin ma = 34'(ptpi_pkg::OneQ30 - cc); mb = 34'(vx_ff); end
      else if (cmd.num_d) begin ma = 34'(cs); mb = 34'(vy_ff); end
      else if (cmd.rot_a) begin ma = dx_ff; mb = 34'(pc_ff); end
      else if (cmd.rot_b) begin ma = dy_ff; mb = 34'(ps_ff); end
      else if (cmd.rot_c) begin ma = dx_ff; mb = 34'(ps_ff); end
      else if (cmd.rot_d) begin ma = dy_ff; mb = 34'(pc_ff); end
      prod = 68'(ma) * 68'(mb);
   end

   // restoring division step
   always_comb begin
      logic [N:0] t;
      t = {rem_ff, quo_ff[N-1]} - {{(N-32){1'b0}}, dmag_ff};
      rem_in = t[N] ? {rem_ff[N-2:0], quo_ff[N-1]} : t[N-1:0];
   end

   always_ff @(posedge clock) begin
      logic signed [N-1:0] q;
      logic signed [33:0] qc;
      logic [N-1:0] nm;
      logic signed [67:0] r;
      logic signed [33:0] s;
      if (reset) begin
         px_ff <= '0; py_ff <= '0; th_ff <= '0;
         pc_ff <= 32'sd1073741824; ps_ff <= '0;
      end else begin
         cx_ff <= cx_in; cy_ff <= cy_in; ca_ff <= ca_in;
         if (cmd.load) begin
            w_ff <= in_w; vx_ff <= in_vx; vy_ff <= in_vy; sat_ff <= 1'b0;
            turn_ff <= ((in_w < 0) ? -32'(in_w) : 32'(in_w)) > 32'(thr);
         end
         if (cmd.cor_start) begin
            cneg_ff <= ((cmd.cor_sel ? A'(th_new) : A'(w_ff)) <<< 2) > ptpi_pkg::HalfPiQ30
                    || ((cmd.cor_sel ? A'(th_new) : A'(w_ff)) <<< 2) < -ptpi_pkg::HalfPiQ30;
         end
         if (cmd.num_x) numx_ff <= prod;
         if (cmd.num_y) numx_ff <= numx_ff + prod;
         if (cmd.num_c) numy_ff <= prod;
         if (cmd.num_d) numy_ff <= numy_ff + prod;
         if (cmd.div_start) begin
            if (!cmd.div_sel) begin
               nm = numx_ff[N-1] ? -numx_ff : numx_ff;
               qneg_ff <= numx_ff[N-1] ^ w_ff[30];
            end else begin
               nm = numy_ff[N-1] ? -numy_ff : numy_ff;
               qneg_ff <= numy_ff[N-1] ^ w_ff[30];
            end
            quo_ff <= nm; rem_ff <= '0;
            dmag_ff <= w_ff[30] ? 33'(-(35'(w_ff) <<< 2)) : 33'(35'(w_ff) <<< 2);
         end
         if (cmd.div_step) begin
            rem_ff <= rem_in;
            quo_ff <= {quo_ff[N-2:0], ~({rem_ff, quo_ff[N-1]} < {1'b0, {(N-32){1'b0}}, dmag_ff})};
         end
         if (cmd.div_done) begin
            q = qneg_ff ? -$signed(quo_ff) : $signed(quo_ff);
            if (q > N'(ptpi_pkg::DispLimit)) begin qc = ptpi_pkg::DispLimit; sat_ff <= 1'b1; end
            else if (q < -N'(ptpi_pkg::DispLimit)) begin
               qc = -ptpi_pkg::DispLimit; sat_ff <= 1'b1;
            end else qc = q[33:0];
            if (cmd.div_sel) dy_ff <= qc; else dx_ff <= qc;
         end
         if (cmd.load) begin
            dx_ff <= 34'(in_vx); dy_ff <= 34'(in_vy);
         end
         if (cmd.rot_a) acc_ff <= prod;
         if (cmd.rot_b) begin
            r = acc_ff - prod + 68'sd536870912;
            s = 34'(r >>> 30);
            s = s + 34'(px_ff);
            acc_ff <= 68'(s);
         end
         if (cmd.rot_c) num_ff <= prod;
         if (cmd.rot_d) begin
            r = num_ff + prod + 68'sd536870912;
            s = 34'(r >>> 30);
            s = s + 34'(py_ff);
            numx_ff <= 68'(s);
         end
         if (cmd.pos_upd) begin
            if ($signed(acc_ff[33:0]) > 34'sd2147483647) begin
               px_ff <= 32'h7fffffff; sat_ff <= 1'b1;
            end else if ($signed(acc_ff[33:0]) < -34'sd2147483648) begin
               px_ff <= 32'h80000000; sat_ff <= 1'b1;
            end else px_ff <= acc_ff[31:0];
            if ($signed(numx_ff[33:0]) > 34'sd2147483647) begin
               py_ff <= 32'h7fffffff; sat_ff <= 1'b1;
            end else if ($signed(numx_ff[33:0]) < -34'sd2147483648) begin
               py_ff <= 32'h80000000; sat_ff <= 1'b1;
            end else py_ff <= numx_ff[31:0];
         end
         if (cmd.pose_trig) begin
            th_ff <= 32'(th_new);
            pc_ff <= 32'(cc); ps_ff <= 32'(cs);
         end
         if (cmd.out_load) begin
            o_x <= px_ff; o_y <= py_ff; o_sat <= sat_ff;
            // heading is stored in the same cycle, so take the new value directly
            o_th <= cmd.pose_trig ? th_new[30:0] : th_ff[30:0];
         end
      end
   end
endmodule

// ===== rtl/core/ptpi_ctrl.sv =====
// Controller state machine sequencing the datapath per transaction.
// Depends on ptpi_pkg.
`timescale 1ns / 1ps
module ptpi_ctrl #(
   parameter int CORDIC_STEPS = ptpi_pkg::CordicSteps
) (
   input  logic clock,
   input  logic reset,
   input  logic in_valid,
   output logic in_ready,
   output logic out_valid,
   input  logic out_ready,
   input  ptpi_pkg::sts_type sts,
   output ptpi_pkg::cmd_type cmd,
   output logic [4:0] step
);
   localparam logic [4:0] S_IDLE = 5'd0, S_C1S = 5'd1, S_C1 = 5'd2, S_NX = 5'd3,
      S_NY = 5'd4, S_NC = 5'd5, S_ND = 5'd6, S_DVS = 5'd7, S_DV = 5'd8, S_DVE = 5'd9,
      S_RA = 5'd10, S_RB = 5'd11, S_RC = 5'd12, S_RD = 5'd13, S_POS = 5'd14,
      S_C2 = 5'd15, S_OUT = 5'd16;
   localparam int DivSteps = ptpi_pkg::NumW;

   logic [4:0] state_ff, state_in;
   logic [6:0] cnt_ff, cnt_in;
   logic dsel_ff, dsel_in, ov_ff, ov_in;

   assign step = cnt_ff[4:0];
   // the result register holds a finished transaction, so the core may start the next
   assign in_ready = (state_ff == S_IDLE);
   assign out_valid = ov_ff;

   always_comb begin
      cmd = '0;
      state_in = state_ff; cnt_in = cnt_ff; dsel_in = dsel_ff;
      ov_in = ov_ff && !out_ready;
      cmd.div_sel = dsel_ff;
      unique case (state_ff)
         S_IDLE: if (in_valid && in_ready) begin
            cmd.load = 1'b1; state_in = S_C1S;
         end
         S_C1S: begin
            if (sts.turning) begin
               cmd.cor_start = 1'b1; cnt_in = '0; state_in = S_C1;
            end else state_in = S_RA;
         end
         S_C1: begin
            cmd.cor_step = 1'b1; cnt_in = cnt_ff + 7'd1;
            if (cnt_ff == 7'(CORDIC_STEPS - 1)) state_in = S_NX;
         end
         S_NX: begin cmd.num_x = 1'b1; state_in = S_NY; end
         S_NY: begin cmd.num_y = 1'b1; state_in = S_NC; end
         S_NC: begin cmd.num_c = 1'b1; state_in = S_ND; end
         S_ND: begin cmd.num_d = 1'b1; dsel_in = 1'b0; state_in = S_DVS; end
         S_DVS: begin cmd.div_start = 1'b1; cnt_in = '0; state_in = S_DV; end
         S_DV: begin
            cmd.div_step = 1'b1; cnt_in = cnt_ff + 7'd1;
            if (cnt_ff == 7'(DivSteps - 1)) state_in = S_DVE;
         end
         S_DVE: begin
            cmd.div_done = 1'b1;
            if (dsel_ff) state_in = S_RA;
            else begin dsel_in = 1'b1; state_in = S_DVS; end
         end
         S_RA: begin cmd.rot_a = 1'b1; state_in = S_RB; end
         S_RB: begin cmd.rot_b = 1'b1; state_in = S_RC; end
         S_RC: begin cmd.rot_c = 1'b1; state_in = S_RD; end
         S_RD: begin cmd.rot_d = 1'b1; state_in = S_POS; end
         S_POS: begin
            cmd.pos_upd = 1'b1;
            if (sts.turning) begin
               cmd.cor_start = 1'b1; cmd.cor_sel = 1'b1; cnt_in = '0; state_in = S_C2;
            end else state_in = S_OUT;
         end
         S_C2: begin
            cmd.cor_step = 1'b1; cnt_in = cnt_ff + 7'd1;
            if (cnt_ff == 7'(CORDIC_STEPS - 1)) begin
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (!ov_ff || out_ready) begin
               cmd.pose_trig = sts.turning; cmd.out_load = 1'b1;
               ov_in = 1'b1; state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE; cnt_ff <= '0; dsel_ff <= 1'b0; ov_ff <= 1'b0;
      end else begin
         state_ff <= state_in; cnt_ff <= cnt_in; dsel_ff <= dsel_in; ov_ff <= ov_in;
      end
   end
endmodule
